// File: design/spt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types, constants, rounding and saturation helpers of the sine pose trajectory.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned RAMP_TICKS_DEF = 1500;
  localparam int unsigned FRAC_BITS_DEF  = 20;

  localparam int unsigned TICK_W    = 24;
  localparam int unsigned NUM_W     = TICK_W + 1;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned LEFT_W    = 25;
  localparam int unsigned AMP_W     = 23;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned HOLD_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // latency of one sine/cosine unit
  localparam int unsigned SC_LAT = 19;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [37:0] TURN_PER_RAD = 38'd174992710548;

  localparam logic [PER_W-1:0] PERIOD_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS   = 3'd0,
    CFG_AMP    = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_PERIOD = 3'd3,
    CFG_HOLD   = 3'd4
  } spt_cfg_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_ROLL = 2'd2,
    AXIS_YAW  = 2'd3
  } spt_axis_e;

  typedef struct packed {
    logic              valid;
    logic              ramp;
    logic [LEFT_W-1:0] left;
  } spt_side_t;

  // round half away from zero, Q30 product down to Q.FRAC
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] rnd;
    logic [33:0] m34;
    mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    rnd = (mag + 64'h2000_0000) >> 30;
    m34 = rnd[33:0];
    return v[63] ? $signed(34'd0 - m34) : $signed(m34);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [33:0] v);
    if (v > 34'sd8388607) begin
      return 24'sh7F_FFFF;
    end else if (v < -34'sd8388608) begin
      return 24'sh80_0000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/spt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_if
// Valid/ready channels for tick items and pose results.
// ----------------------------------------------------------------------------
interface spt_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] tick_index;

  modport source (output valid, output tick_index, input ready);
  modport sink   (input valid, input tick_index, output ready);
endinterface

interface spt_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] offset_x;
  logic signed [23:0] offset_y;
  logic signed [23:0] offset_z;
  logic signed [23:0] angle_first;
  logic signed [23:0] angle_second;
  logic signed [23:0] angle_third;
  logic        [24:0] ticks_left;

  modport source (output valid, output offset_x, output offset_y, output offset_z,
                  output angle_first, output angle_second, output angle_third,
                  output ticks_left, input ready);
  modport sink   (input valid, input offset_x, input offset_y, input offset_z,
                  input angle_first, input angle_second, input angle_third,
                  input ticks_left, output ready);
endinterface
`default_nettype wire

// File: design/sine_pose_trajectory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_pose_trajectory
// Sine motion body pose offsets and remaining ticks, one sample per tick.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls; the 57-cell phase divider
//   row and the two sine/cosine pipelines each take a new item every cycle
// a stalled output freezes the whole pipeline
// reset: registers to defaults (period 1000, others 0), all stages empty
module sine_pose_trajectory #(
  parameter int unsigned RAMP_TICKS = spt_pkg::RAMP_TICKS_DEF,
  parameter int unsigned FRAC_BITS  = spt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [spt_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  spt_in_if.sink                               in_i,
  spt_out_if.source                            out_o
);
  import spt_pkg::*;

  localparam int unsigned DEN_W = ($clog2(2 * RAMP_TICKS + 1) > PER_W) ?
                                  $clog2(2 * RAMP_TICKS + 1) : PER_W;
  localparam int unsigned DIV_N = NUM_W + PHASE_W;
  localparam int unsigned PH_SH = FRAC_BITS + 8;
  localparam logic [TICK_W-1:0] RAMP_K   = TICK_W'(RAMP_TICKS);
  localparam logic [NUM_W-1:0]  RAMP_N   = NUM_W'(RAMP_TICKS);
  localparam logic [DEN_W-1:0]  RAMP_DEN = DEN_W'(2 * RAMP_TICKS);
  localparam logic [26:0]       RAMP_L   = 27'(RAMP_TICKS);

  typedef struct packed {
    logic                    valid;
    logic                    ramp;
    logic [LEFT_W-1:0]       left;
    logic signed [OUT_W-1:0] a;
  } pipe_t;

  // configuration registers
  spt_axis_e          axis_q;
  logic [AMP_W-1:0]   amp_q, radius_q;
  logic [PER_W-1:0]   period_q;
  logic [HOLD_W-1:0]  hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXIS_NONE;
      amp_q    <= '0;
      radius_q <= '0;
      period_q <= PERIOD_RST;
      hold_q   <= '0;
    end else if (cfg_we_i) begin
      case (spt_cfg_e'(cfg_idx_i))
        CFG_AXIS:   axis_q   <= spt_axis_e'(cfg_data_i[1:0]);
        CFG_AMP:    amp_q    <= cfg_data_i[AMP_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[AMP_W-1:0];
        CFG_PERIOD: period_q <= cfg_data_i[PER_W-1:0];
        CFG_HOLD:   hold_q   <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  // input stage: divider operands and remaining ticks
  logic [TICK_W-1:0] k;
  logic              ramp_d;
  logic [NUM_W-1:0]  num_d;
  logic [DEN_W-1:0]  den_d;
  logic [26:0]       total, used;
  logic [LEFT_W-1:0] left_d;

  always_comb begin
    k      = in_i.tick_index;
    ramp_d = k <= RAMP_K;
    num_d  = NUM_W'(k) + NUM_W'(1) - (ramp_d ? '0 : RAMP_N);
    if (ramp_d) begin
      den_d = RAMP_DEN;
    end else begin
      den_d = (period_q == '0) ? DEN_W'(1) : DEN_W'(period_q);
    end
    total  = 27'(hold_q) + RAMP_L + 27'(period_q >> 2);
    used   = 27'(k) + 27'd1;
    left_d = (total > used) ? LEFT_W'(total - used) : '0;
  end

  spt_side_t        dv_side[DIV_N+1];
  logic [NUM_W-1:0] dv_num [DIV_N+1];
  logic [DEN_W-1:0] dv_den [DIV_N+1];
  logic [DEN_W-1:0] dv_rem [DIV_N+1];
  logic [31:0]      dv_quo [DIV_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_side[0] <= '0;
    end else if (en) begin
      dv_side[0] <= '{valid: in_i.valid, ramp: ramp_d, left: left_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num[0] <= num_d;
      dv_den[0] <= den_d;
    end
  end

  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;

  // phase = floor(num * 2^32 / den) mod 2^32, one bit per cell
  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic bit_in;
    if (i < NUM_W) begin : g_int
      assign bit_in = dv_num[i][NUM_W-1-i];
    end else begin : g_frac
      assign bit_in = 1'b0;
    end
    spt_div_cell #(.DEN_W(DEN_W), .NUM_W(NUM_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .bit_i(bit_in),
      .side_i(dv_side[i]), .num_i(dv_num[i]), .den_i(dv_den[i]),
      .rem_i(dv_rem[i]), .quo_i(dv_quo[i]),
      .side_o(dv_side[i+1]), .num_o(dv_num[i+1]), .den_o(dv_den[i+1]),
      .rem_o(dv_rem[i+1]), .quo_o(dv_quo[i+1])
    );
  end

  // weight phase sine/cosine
  logic signed [31:0] s1, c1;
  pipe_t              tr1_q[SC_LAT];

  spt_sincos u_sc_weight (
    .clk_i, .en_i(en), .phase_i(dv_quo[DIV_N]), .sin_o(s1), .cos_o(c1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SC_LAT; i++) begin
        tr1_q[i] <= '0;
      end
    end else if (en) begin
      tr1_q[0] <= '{valid: dv_side[DIV_N].valid, ramp: dv_side[DIV_N].ramp,
                    left: dv_side[DIV_N].left, a: '0};
      for (int i = 1; i < SC_LAT; i++) begin
        tr1_q[i] <= tr1_q[i-1];
      end
    end
  end

  // weight, amplitude product, angle, angle phase
  pipe_t              w_tr_q, m_tr_q, a_tr_q, p1_tr_q, p2_tr_q;
  logic signed [31:0] w_q;
  logic signed [55:0] prod_q;
  logic [42:0]        ph_hi_q, ph_lo_q;
  logic [31:0]        phase2_q;

  logic signed [32:0] om1;
  logic signed [31:0] w_d;
  logic signed [OUT_W-1:0] a_d;
  logic [OUT_W-1:0]   a_mag;
  logic [61:0]        ph_sum, ph_shift;
  logic [31:0]        ph_d;

  always_comb begin
    om1    = $signed({2'b00, Q30_ONE}) - 33'(c1);
    w_d    = tr1_q[SC_LAT-1].ramp ? om1[32:1] : c1;
    a_d    = sat24(round_q30(64'(prod_q)));
    a_mag  = a_tr_q.a[OUT_W-1] ? (OUT_W'(0) - OUT_W'(a_tr_q.a)) : OUT_W'(a_tr_q.a);
    ph_sum = (62'(ph_hi_q) << 19) + 62'(ph_lo_q);
    ph_shift = ph_sum >> PH_SH;
    ph_d   = p1_tr_q.a[OUT_W-1] ? (32'd0 - ph_shift[31:0]) : ph_shift[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_tr_q  <= '0;
      m_tr_q  <= '0;
      a_tr_q  <= '0;
      p1_tr_q <= '0;
      p2_tr_q <= '0;
    end else if (en) begin
      w_tr_q  <= tr1_q[SC_LAT-1];
      m_tr_q  <= w_tr_q;
      a_tr_q  <= '{valid: m_tr_q.valid, ramp: m_tr_q.ramp, left: m_tr_q.left, a: a_d};
      p1_tr_q <= a_tr_q;
      p2_tr_q <= p1_tr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q      <= w_d;
      prod_q   <= $signed({1'b0, amp_q}) * w_q;
      ph_hi_q  <= 43'(a_mag) * 43'(TURN_PER_RAD[37:19]);
      ph_lo_q  <= 43'(a_mag) * 43'(TURN_PER_RAD[18:0]);
      phase2_q <= ph_d;
    end
  end

  // angle sine/cosine
  logic signed [31:0] s2, c2;
  pipe_t              tr2_q[SC_LAT];

  spt_sincos u_sc_angle (
    .clk_i, .en_i(en), .phase_i(phase2_q), .sin_o(s2), .cos_o(c2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SC_LAT; i++) begin
        tr2_q[i] <= '0;
      end
    end else if (en) begin
      tr2_q[0] <= p2_tr_q;
      for (int i = 1; i < SC_LAT; i++) begin
        tr2_q[i] <= tr2_q[i-1];
      end
    end
  end

  // radius products, then rounding and axis selection into the output register
  pipe_t              r_tr_q;
  logic signed [56:0] py_q, ps_q;
  logic signed [32:0] om2;

  assign om2 = $signed({2'b00, Q30_ONE}) - 33'(c2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_tr_q <= '0;
    end else if (en) begin
      r_tr_q <= tr2_q[SC_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      py_q <= $signed({1'b0, radius_q}) * om2;
      ps_q <= $signed({1'b0, radius_q}) * 33'(s2);
    end
  end

  logic signed [OUT_W-1:0] ry, rs, rz;
  logic signed [OUT_W-1:0] x_d, y_d, z_d, af_d, at_d;

  always_comb begin
    ry = sat24(round_q30(64'(py_q)));
    rs = sat24(round_q30(64'(ps_q)));
    rz = sat24(-round_q30(64'(ps_q)));
    x_d  = '0;
    y_d  = '0;
    z_d  = '0;
    af_d = '0;
    at_d = '0;
    case (axis_q)
      AXIS_Y: begin
        y_d = r_tr_q.a;
      end
      AXIS_ROLL: begin
        y_d  = ry;
        z_d  = rz;
        af_d = r_tr_q.a;
      end
      AXIS_YAW: begin
        y_d  = ry;
        x_d  = rs;
        at_d = r_tr_q.a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= r_tr_q.valid;
    end
  end

  logic signed [OUT_W-1:0] ox_q, oy_q, oz_q, oaf_q, oat_q;
  logic [LEFT_W-1:0]       left_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q   <= x_d;
      oy_q   <= y_d;
      oz_q   <= z_d;
      oaf_q  <= af_d;
      oat_q  <= at_d;
      left_q <= r_tr_q.left;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.offset_x     = ox_q;
  assign out_o.offset_y     = oy_q;
  assign out_o.offset_z     = oz_q;
  assign out_o.angle_first  = oaf_q;
  assign out_o.angle_second = '0;
  assign out_o.angle_third  = oat_q;
  assign out_o.ticks_left   = left_q;

endmodule
`default_nettype wire

// File: design/spt_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_div_cell
// One restoring division step; a row of these forms the phase divider.
// ----------------------------------------------------------------------------
module spt_div_cell #(
  parameter int unsigned DEN_W = 17,
  parameter int unsigned NUM_W = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               bit_i,
  input  spt_pkg::spt_side_t      side_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  input  wire logic [DEN_W-1:0]   rem_i,
  input  wire logic [31:0]        quo_i,
  output spt_pkg::spt_side_t      side_o,
  output logic      [NUM_W-1:0]   num_o,
  output logic      [DEN_W-1:0]   den_o,
  output logic      [DEN_W-1:0]   rem_o,
  output logic      [31:0]        quo_o
);
  import spt_pkg::*;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_d;

  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, den_i};
    fits  = trial >= {1'b0, den_i};
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else if (en_i) begin
      side_o <= side_i;
    end
  end

  // integer quotient bits fall off the top, the fraction stays
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i;
      den_o <= den_i;
      rem_o <= rem_d;
      quo_o <= {quo_i[30:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: design/spt_horner_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_horner_cell
// One Horner step t' = 1 - floor((x2*t)/DIV) in Q30, three stages.
// ----------------------------------------------------------------------------
module spt_horner_cell #(
  parameter int unsigned DIV = 2
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [29:0] x_i,
  input  wire logic [29:0] x2_i,
  input  wire logic [30:0] t_i,
  output logic      [29:0] x_o,
  output logic      [29:0] x2_o,
  output logic      [30:0] t_o
);
  import spt_pkg::*;

  localparam logic [32:0] RECIP_FULL = (33'd1 << 32) / DIV;
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [30:0] DIV_V      = 31'(DIV);

  logic [29:0] p_a_q, x_a_q, x2_a_q;
  logic [29:0] m_b_q, p_b_q, x_b_q, x2_b_q;
  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [30:0] md, r, quo;

  always_comb begin
    prod_a = 61'(x2_i) * 61'(t_i);
    prod_b = 62'(p_a_q) * 62'(RECIP);
    // reciprocal estimate is low by at most one
    md     = 31'({1'b0, m_b_q}) * DIV_V;
    r      = {1'b0, p_b_q} - md;
    quo    = {1'b0, m_b_q} + ((r >= DIV_V) ? 31'd1 : 31'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q  <= prod_a[59:30];
      x_a_q  <= x_i;
      x2_a_q <= x2_i;
      m_b_q  <= prod_b[61:32];
      p_b_q  <= p_a_q;
      x_b_q  <= x_a_q;
      x2_b_q <= x2_a_q;
      t_o    <= Q30_ONE - quo;
      x_o    <= x_b_q;
      x2_o   <= x2_b_q;
    end
  end

endmodule
`default_nettype wire

// File: design/spt_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spt_sincos
// Pipelined Q30 sine and cosine of a 32-bit turn phase, octant folded.
// ----------------------------------------------------------------------------
module spt_sincos (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [31:0]        phase_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);
  import spt_pkg::*;

  localparam int unsigned COS_N = 5;
  localparam int unsigned SIN_N = 4;
  localparam int unsigned COS_DIV [COS_N] = '{90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SIN_N] = '{72, 42, 20, 6};
  localparam int unsigned INFO_N = SC_LAT - 1;

  typedef struct packed {
    logic [1:0] quad;
    logic       lower;
  } info_t;

  info_t       info_q [INFO_N];
  logic [29:0] u_q, x_q, x2_q, xs_q;
  logic [61:0] xprod;
  logic [59:0] sqprod;
  logic [29:0] u_d;

  logic [29:0] cx [COS_N+1];
  logic [29:0] cx2[COS_N+1];
  logic [30:0] ct [COS_N+1];
  logic [29:0] sx [SIN_N+1];
  logic [29:0] sx2[SIN_N+1];
  logic [30:0] st [SIN_N+1];

  logic [60:0] sprod;
  logic [29:0] s_m_q, s_p1_q, s_p2_q;
  logic signed [31:0] sv, cv, sin_d, cos_d;
  info_t       info_last;

  always_comb begin
    u_d    = phase_i[29] ? 30'(Q30_ONE - {1'b0, phase_i[29:0]}) : phase_i[29:0];
    xprod  = 62'(u_q) * 62'(PI_Q30);
    sqprod = 60'(x_q) * 60'(x_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q       <= u_d;
      info_q[0] <= '{quad: phase_i[31:30], lower: !phase_i[29]};
      x_q       <= xprod[60:31];
      x2_q      <= sqprod[59:30];
      xs_q      <= x_q;
      for (int i = 1; i < INFO_N; i++) begin
        info_q[i] <= info_q[i-1];
      end
    end
  end

  assign cx[0]  = xs_q;
  assign cx2[0] = x2_q;
  assign ct[0]  = Q30_ONE;
  assign sx[0]  = xs_q;
  assign sx2[0] = x2_q;
  assign st[0]  = Q30_ONE;

  for (genvar i = 0; i < COS_N; i++) begin : g_cos
    spt_horner_cell #(.DIV(COS_DIV[i])) u_cell (
      .clk_i, .en_i,
      .x_i(cx[i]), .x2_i(cx2[i]), .t_i(ct[i]),
      .x_o(cx[i+1]), .x2_o(cx2[i+1]), .t_o(ct[i+1])
    );
  end

  for (genvar i = 0; i < SIN_N; i++) begin : g_sin
    spt_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
      .clk_i, .en_i,
      .x_i(sx[i]), .x2_i(sx2[i]), .t_i(st[i]),
      .x_o(sx[i+1]), .x2_o(sx2[i+1]), .t_o(st[i+1])
    );
  end

  // sine lane is one Horner step short: final x multiply, then pad
  assign sprod = 61'(sx[SIN_N]) * 61'(st[SIN_N]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_m_q  <= sprod[59:30];
      s_p1_q <= s_m_q;
      s_p2_q <= s_p1_q;
    end
  end

  always_comb begin
    info_last = info_q[INFO_N-1];
    if (info_last.lower) begin
      sv = $signed({2'b00, s_p2_q});
      cv = $signed({1'b0, ct[COS_N]});
    end else begin
      sv = $signed({1'b0, ct[COS_N]});
      cv = $signed({2'b00, s_p2_q});
    end
    case (info_last.quad)
      2'd0: begin
        sin_d = sv;
        cos_d = cv;
      end
      2'd1: begin
        sin_d = cv;
        cos_d = -sv;
      end
      2'd2: begin
        sin_d = -sv;
        cos_d = -cv;
      end
      default: begin
        sin_d = -cv;
        cos_d = sv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sine pose trajectory. Tick items go in over a valid/ready
// channel. A pose predictor works out the expected pose and remaining ticks
// for each transfer. Each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  localparam int unsigned RAMP  = RAMP_TICKS_DEF;
  localparam int unsigned FRAC  = FRAC_BITS_DEF;
  localparam longint Q_ONE      = 64'd1 << 30;
  localparam longint unsigned PI_K   = 64'd3373259426;
  localparam longint unsigned TURN_K = 64'd174992710548;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [22:0] Q_MAX = 23'h7F_FFFF;

  typedef struct {
    logic signed [OUT_W-1:0] off_x;
    logic signed [OUT_W-1:0] off_y;
    logic signed [OUT_W-1:0] off_z;
    logic signed [OUT_W-1:0] ang_a;
    logic signed [OUT_W-1:0] ang_b;
    logic signed [OUT_W-1:0] ang_c;
    logic [LEFT_W-1:0]       left;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  spt_in_if  tick_ch ();
  spt_out_if pose_ch ();

  sine_pose_trajectory uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_ch.sink),
    .out_o      (pose_ch.source)
  );

  // predictor copy of the registers
  spt_axis_e   mdl_axis;
  logic [22:0] mdl_amp;
  logic [22:0] mdl_radius;
  logic [15:0] mdl_period;
  logic [23:0] mdl_hold;

  pose_t  pose_q[$];
  int     n_errors;
  int     n_sent;
  int     n_checked;
  int     src_idle_pct;
  int     snk_stall_pct;
  longint cycles;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.tick_index = '0;
    pose_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_AXIS;
    cfg_data_i = '0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned sin_octant(input longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = Q_ONE;
    t = Q_ONE - ((x2 * t) >> 30) / 72;
    t = Q_ONE - ((x2 * t) >> 30) / 42;
    t = Q_ONE - ((x2 * t) >> 30) / 20;
    t = Q_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic longint unsigned cos_octant(input longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = Q_ONE;
    t = Q_ONE - ((x2 * t) >> 30) / 90;
    t = Q_ONE - ((x2 * t) >> 30) / 56;
    t = Q_ONE - ((x2 * t) >> 30) / 30;
    t = Q_ONE - ((x2 * t) >> 30) / 12;
    t = Q_ONE - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  task automatic sin_cos(input logic [31:0] ph, output longint s, output longint c);
    longint unsigned f, x;
    longint sv, cv;
    f = ph[29:0];
    if (f < (64'd1 << 29)) begin
      x = (f * PI_K) >> 31;
      sv = sin_octant(x);
      cv = cos_octant(x);
    end else begin
      x = (((64'd1 << 30) - f) * PI_K) >> 31;
      sv = cos_octant(x);
      cv = sin_octant(x);
    end
    case (ph[31:30])
      2'd0: begin s = sv;  c = cv;  end
      2'd1: begin s = cv;  c = -sv; end
      2'd2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endtask

  function automatic longint shift_round(input longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic predict_pose(input logic [23:0] k, output pose_t p);
    longint unsigned per, num, den, m, ph;
    longint s, c, w, a, sn, left;
    per = (mdl_period == 0) ? 1 : mdl_period;
    if (k <= RAMP) begin
      num = k + 1;
      den = 2 * RAMP;
    end else begin
      num = k - RAMP + 1;
      den = per;
    end
    sin_cos(32'(((num % den) << 32) / den), s, c);
    w = (k <= RAMP) ? ((Q_ONE - c) >>> 1) : c;
    a = clamp24(shift_round(longint'(mdl_amp) * w));
    p = '{default: '0};
    if (mdl_axis == AXIS_Y) begin
      p.off_y = OUT_W'(a);
    end else if (mdl_axis != AXIS_NONE) begin
      m = a < 0 ? -a : a;
      ph = (m * TURN_K) >> (FRAC + 8);
      if (a < 0) ph = -ph;
      sin_cos(32'(ph), sn, c);
      p.off_y = OUT_W'(clamp24(shift_round(longint'(mdl_radius) * (Q_ONE - c))));
      if (mdl_axis == AXIS_ROLL) begin
        p.ang_a = OUT_W'(a);
        p.off_z = OUT_W'(clamp24(-shift_round(longint'(mdl_radius) * sn)));
      end else begin
        p.ang_c = OUT_W'(a);
        p.off_x = OUT_W'(clamp24(shift_round(longint'(mdl_radius) * sn)));
      end
    end
    left = longint'(mdl_hold) + RAMP + (mdl_period / 4) - longint'(k) - 1;
    p.left = (left < 0) ? '0 : left[LEFT_W-1:0];
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni) begin
      if (pose_ch.valid && pose_ch.ready) begin
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          e = pose_q.pop_front();
          n_checked++;
          if (pose_ch.offset_x !== e.off_x) report_mismatch("offset_x", pose_ch.offset_x, e.off_x);
          if (pose_ch.offset_y !== e.off_y) report_mismatch("offset_y", pose_ch.offset_y, e.off_y);
          if (pose_ch.offset_z !== e.off_z) report_mismatch("offset_z", pose_ch.offset_z, e.off_z);
          if (pose_ch.angle_first !== e.ang_a)
            report_mismatch("angle_first", pose_ch.angle_first, e.ang_a);
          if (pose_ch.angle_second !== e.ang_b)
            report_mismatch("angle_second", pose_ch.angle_second, e.ang_b);
          if (pose_ch.angle_third !== e.ang_c)
            report_mismatch("angle_third", pose_ch.angle_third, e.ang_c);
          if (pose_ch.ticks_left !== e.left)
            report_mismatch("ticks_left", pose_ch.ticks_left, e.left);
        end
      end
      pose_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_AXIS:   mdl_axis = spt_axis_e'(val[1:0]);
      CFG_AMP:    mdl_amp = val[22:0];
      CFG_RADIUS: mdl_radius = val[22:0];
      CFG_PERIOD: mdl_period = val[15:0];
      CFG_HOLD:   mdl_hold = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_motion(input spt_axis_e ax, input logic [22:0] amp,
                            input logic [22:0] rad, input logic [15:0] per,
                            input logic [23:0] hold);
    write_reg(CFG_AXIS, CFG_DAT_W'(ax));
    write_reg(CFG_AMP, CFG_DAT_W'(amp));
    write_reg(CFG_RADIUS, CFG_DAT_W'(rad));
    write_reg(CFG_PERIOD, CFG_DAT_W'(per));
    write_reg(CFG_HOLD, hold);
  endtask

  // valid stays high across back-to-back items, lowered only for a gap or by wait_idle
  task automatic send_tick(input logic [23:0] k);
    pose_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.tick_index <= k;
    predict_pose(k, p);
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    pose_q.push_back(p);
    n_sent++;
  endtask

  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_tick();
    case ($urandom_range(9))
      0: return 24'($urandom_range(24'hFF_FFFF));
      1: return 24'(RAMP + $urandom_range(2) - 1);
      2, 3: return 24'($urandom_range(RAMP));
      default: return 24'(RAMP + $urandom_range(2 * 65536));
    endcase
  endfunction

  function automatic logic [22:0] pick_q();
    case ($urandom_range(5))
      0: return '0;
      1: return Q_MAX;
      default: return 23'($urandom_range(Q_MAX));
    endcase
  endfunction

  task automatic test_reset_values();
    send_tick('0);
    send_tick(24'(RAMP));
    send_tick(24'(RAMP + 250));
    wait_idle();
  endtask

  task automatic test_ramp_and_edges();
    set_motion(AXIS_Y, Q_MAX, '0, 16'd1000, '0);
    send_tick('0);
    send_tick(24'd1);
    send_tick(24'(RAMP / 2));
    send_tick(24'(RAMP - 1));
    send_tick(24'(RAMP));
    send_tick(24'(RAMP + 1));
    send_tick(24'(RAMP + 500));
    send_tick(24'hFF_FFFF);
    send_tick(24'h55_5555);
    send_tick(24'hAA_AAAA);
    wait_idle();
    // zero period holds the weight at one, tiny periods used as they are
    write_reg(CFG_PERIOD, '0);
    send_tick(24'(RAMP + 7));
    wait_idle();
    write_reg(CFG_PERIOD, 24'd1);
    send_tick(24'(RAMP + 3));
    wait_idle();
    write_reg(CFG_PERIOD, 24'd3);
    send_tick(24'(RAMP + 1));
    send_tick(24'(RAMP + 2));
    wait_idle();
    // unknown register indexes must leave the registers alone
    write_reg(IDX_SPARE_LO, 24'hFF_FFFF);
    write_reg(IDX_SPARE_HI, 24'hFF_FFFF);
    write_reg(CFG_HOLD, 24'hFF_FFFF);
    write_reg(CFG_PERIOD, 24'h00_FFFF);
    send_tick('0);
    send_tick(24'hFF_FFFF);
    wait_idle();
  endtask

  task automatic test_rotations();
    // large angle with full radius drives r(1-cos) into saturation
    set_motion(AXIS_ROLL, Q_MAX, Q_MAX, 16'd4, '0);
    send_tick(24'(RAMP));
    send_tick(24'(RAMP + 1));
    send_tick(24'(RAMP + 2));
    send_tick(24'(RAMP / 3));
    wait_idle();
    write_reg(CFG_AXIS, CFG_DAT_W'(AXIS_YAW));
    send_tick(24'(RAMP));
    send_tick(24'(RAMP + 1));
    send_tick(24'(RAMP + 3));
    send_tick(24'(RAMP / 4));
    wait_idle();
  endtask

  task automatic test_random_motion(input int idle_pct, input int stall_pct, input int n);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    for (int blk = 0; blk < 4; blk++) begin
      set_motion(spt_axis_e'($urandom_range(3)), pick_q(), pick_q(),
                 16'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                              : $urandom_range(4, 3000)),
                 24'(($urandom_range(3) == 0) ? $urandom_range(24'hFF_FFFF)
                                              : $urandom_range(5000)));
      for (int i = 0; i < n / 4; i++) send_tick(pick_tick());
      wait_idle();
    end
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    mdl_axis = AXIS_NONE;
    mdl_amp = '0;
    mdl_radius = '0;
    mdl_period = PERIOD_RST;
    mdl_hold = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_ramp_and_edges();
    test_rotations();
    test_random_motion(0, 0, 160);
    test_random_motion(57, 0, 160);
    test_random_motion(0, 57, 160);
    test_random_motion(23, 23, 160);

    if (pose_q.size() != 0) report_mismatch("results never arrived", 0, pose_q.size());
    $display("%0d ticks sent, %0d poses checked over all four axis modes,", n_sent, n_checked);
    $display("ramp and oscillation ticks, saturation and sender/receiver idling");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
